[sv/date_difference_in_days_defines.svh]
// ----------------------------------------------------------------------------
// date difference assertion macros
// concurrent assertion wrappers, removable with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef DATE_DIFFERENCE_IN_DAYS_DEFINES_SVH
`define DATE_DIFFERENCE_IN_DAYS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define DD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define DD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DD_ASSERT(lbl, prop, msg)
`define DD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/dd_pkg.sv]
// ----------------------------------------------------------------------------
// dd_pkg
// shared types and constants of the date difference block
// ----------------------------------------------------------------------------
package dd_pkg;

  localparam int DAYNUM_W  = 22;  // day number of one date, max 3652493
  localparam int DIFF_W    = 23;
  localparam int YEAR_W    = 14;
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  typedef struct packed {
    logic [31:0] first_date_bcd;
    logic [31:0] second_date_bcd;
  } dd_in_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] day_difference;
    logic                     bad_input;
  } dd_out_t;

  // one decoded date
  typedef struct packed {
    logic [6:0]       day;
    logic [3:0]       month_idx;  // month minus one
    logic [3:0][3:0]  year_bcd;   // thousands digit first
  } dd_date_t;

  // classified item handed from front to back
  typedef struct packed {
    dd_date_t [1:0] date;       // index 1 is the first date
    logic           bad;
  } dd_item_t;

  // days before the first of each month in a common year
  function automatic logic [8:0] month_start(logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[sv/date_difference_in_days.sv]
// ----------------------------------------------------------------------------
// date_difference_in_days
// signed day count between two bcd dates (ddmmyyyy), first minus second
// ----------------------------------------------------------------------------
//  channel  | ports                       | direction
//  ---------+-----------------------------+----------
//  input    | push, full, in_data         | in
//  result   | pop, empty, out_data        | out
//
//  one transfer per cycle sustained on both sides while the result side keeps popping
//  after its input transfer a result passes the middle queue, year stage,
//  day-number stage and output queue before it shows on out_data
//  the day-number stage (365 times year plus leap and month terms) sets the path
//  rst_n is synchronous; it empties both queues and the pipeline
//  a stalled output fills the output queue, then the pipeline, then the middle queue
// ----------------------------------------------------------------------------
`include "date_difference_in_days_defines.svh"

module date_difference_in_days import dd_pkg::*; #(
  parameter int MID_QDEPTH = MID_DEPTH,  // front-to-back queue entries, at least 2
  parameter int OUT_QDEPTH = OUT_DEPTH   // result queue entries, at least 2
) (
  input  logic    clk,
  input  logic    rst_n,
  // input channel
  input  logic    push,
  output logic    full,
  input  dd_in_t  in_data,
  // result channel
  input  logic    pop,
  output logic    empty,
  output dd_out_t out_data
);

  // one above the largest day count of one date, bounds the difference
  localparam int DIFF_SPAN = 3652494;

  // front to back
  logic     mid_push, mid_full, mid_pop, mid_empty;
  dd_item_t mid_wr, mid_rd;

  // back to output queue
  logic     res_push, res_full;
  dd_out_t  res_item;

  // head of the result queue, for the checks below
  logic                     head_bad;
  logic signed [DIFF_W-1:0] head_diff;
  logic                     diff_in_span;

  // decode and classify each transfer
  dd_front u_front (
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_push  (mid_push),
    .q_full  (mid_full),
    .q_item  (mid_wr)
  );

  // decouples the front from back-pressure in the pipeline
  dd_fifo #(
    .DEPTH (MID_QDEPTH),
    .T     (dd_item_t)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_push),
    .wr_data (mid_wr),
    .full    (mid_full),
    .rd_en   (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  // day numbers of both dates and their difference
  dd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (mid_empty),
    .q_item  (mid_rd),
    .q_pop   (mid_pop),
    .o_full  (res_full),
    .o_push  (res_push),
    .o_item  (res_item)
  );

  // result queue, head drives the output ports
  dd_fifo #(
    .DEPTH (OUT_QDEPTH),
    .T     (dd_out_t)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_item),
    .full    (res_full),
    .rd_en   (pop && !empty),
    .rd_data (out_data),
    .empty   (empty)
  );

  assign head_bad     = !empty && out_data.bad_input;
  assign head_diff    = out_data.day_difference;
  assign diff_in_span = (head_diff <= DIFF_SPAN) && (head_diff >= -DIFF_SPAN);

  // both queues come out of reset empty with room
  `DD_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> empty && !full && mid_empty, "reset left data")
  // an accepted item is in the middle queue on the next cycle
  `DD_ASSERT(a_front_lands, mid_push |=> !mid_empty, "accepted item missing from queue")
  // a rejected pair carries a zero difference
  `DD_ASSERT(a_bad_zero, head_bad |-> head_diff == '0, "bad input with nonzero difference")
  // difference stays within the span of four-digit years
  `DD_ASSERT(a_diff_range, !empty |-> diff_in_span, "difference out of range")

endmodule

[sv/dd_fifo.sv]
// ----------------------------------------------------------------------------
// dd_fifo
// small register queue, head shown while not empty
// ----------------------------------------------------------------------------
module dd_fifo import dd_pkg::*; #(
  parameter int  DEPTH = MID_DEPTH,  // at least 2
  parameter type T     = dd_item_t
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  T     wr_data,
  output logic full,
  input  logic rd_en,
  output T     rd_data,
  output logic empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  T              mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);

endmodule

[sv/dd_front.sv]
// ----------------------------------------------------------------------------
// dd_front
// input side: takes a date pair, decodes digits, flags bad dates
// ----------------------------------------------------------------------------
module dd_front import dd_pkg::*; (
  input  logic     push,
  output logic     full,
  input  dd_in_t   in_data,
  output logic     q_push,
  input  logic     q_full,
  output dd_item_t q_item
);

  function automatic logic date_ok(logic [31:0] bcd);
    logic       nib_ok;
    logic [6:0] mval;
    nib_ok = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (bcd[4*i +: 4] > 4'd9) begin
        nib_ok = 1'b0;
      end
    end
    mval = 7'(bcd[23:20]) * 7'd10 + 7'(bcd[19:16]);
    return nib_ok && (mval >= 7'd1) && (mval <= 7'd12);
  endfunction

  function automatic dd_date_t decode(logic [31:0] bcd);
    dd_date_t   d;
    logic [6:0] mval;
    mval        = 7'(bcd[23:20]) * 7'd10 + 7'(bcd[19:16]);
    d.day       = 7'(bcd[31:28]) * 7'd10 + 7'(bcd[27:24]);
    d.month_idx = 4'(mval - 7'd1);
    d.year_bcd  = bcd[15:0];
    return d;
  endfunction

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_item.date[1] = decode(in_data.first_date_bcd);
    q_item.date[0] = decode(in_data.second_date_bcd);
    q_item.bad     = !(date_ok(in_data.first_date_bcd) && date_ok(in_data.second_date_bcd));
  end

endmodule

[sv/dd_back.sv]
// ----------------------------------------------------------------------------
// dd_back
// two-stage day-number pipeline and final subtraction
// ----------------------------------------------------------------------------
module dd_back import dd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  dd_item_t q_item,
  output logic     q_pop,
  input  logic     o_full,
  output logic     o_push,
  output dd_out_t  o_item
);

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [6:0]        cent_prev;  // (year-1)/100 for year above zero
    logic              leap;
    logic [3:0]        month_idx;
    logic [6:0]        day;
  } dd_yinfo_t;

  logic                      va_r, vb_r;
  dd_yinfo_t [1:0]           sa_r, sa_nxt;
  logic                      bad_a_r, bad_b_r;
  logic [1:0][DAYNUM_W-1:0]  dn_r, dn_nxt;
  logic                      adv_a, adv_b;
  logic signed [DIFF_W-1:0]  diff;

  // stall chain from the output queue back
  assign adv_b  = !vb_r || !o_full;
  assign adv_a  = !va_r || adv_b;
  assign q_pop  = !q_empty && adv_a;
  assign o_push = vb_r && !o_full;

  // stage a: binary year, century and leap flag
  always_comb begin
    logic [6:0] cent;
    logic [6:0] lo;
    logic       lo_zero;
    for (int k = 0; k < 2; k++) begin
      cent    = 7'(q_item.date[k].year_bcd[3]) * 7'd10 + 7'(q_item.date[k].year_bcd[2]);
      lo      = 7'(q_item.date[k].year_bcd[1]) * 7'd10 + 7'(q_item.date[k].year_bcd[0]);
      lo_zero = (lo == 7'd0);
      sa_nxt[k].year      = YEAR_W'(cent) * YEAR_W'(100) + YEAR_W'(lo);
      sa_nxt[k].cent_prev = lo_zero ? cent - 7'd1 : cent;
      sa_nxt[k].leap      = lo_zero ? (cent[1:0] == 2'd0) : (lo[1:0] == 2'd0);
      sa_nxt[k].month_idx = q_item.date[k].month_idx;
      sa_nxt[k].day       = q_item.date[k].day;
    end
  end

  // stage b: day number from 1 january of year zero
  always_comb begin
    logic [11:0] leaps;
    logic [11:0] quarter;
    for (int k = 0; k < 2; k++) begin
      quarter = 12'((sa_r[k].year - YEAR_W'(1)) >> 2);
      if (sa_r[k].year == '0) begin
        leaps = '0;
      end else begin
        leaps = quarter - 12'(sa_r[k].cent_prev) + 12'(sa_r[k].cent_prev >> 2) + 12'd1;
      end
      dn_nxt[k] = DAYNUM_W'(sa_r[k].year) * DAYNUM_W'(365) + DAYNUM_W'(leaps)
                + DAYNUM_W'(month_start(sa_r[k].month_idx)) + DAYNUM_W'(sa_r[k].day)
                + DAYNUM_W'(sa_r[k].leap && (sa_r[k].month_idx >= 4'd2));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (adv_a) begin
        va_r <= q_pop;
      end
      if (adv_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sa_r    <= sa_nxt;
      bad_a_r <= q_item.bad;
    end
    if (va_r && adv_b) begin
      dn_r    <= dn_nxt;
      bad_b_r <= bad_a_r;
    end
  end

  assign diff = $signed({1'b0, dn_r[1]}) - $signed({1'b0, dn_r[0]});

  always_comb begin
    o_item.bad_input      = bad_b_r;
    o_item.day_difference = bad_b_r ? '0 : diff;
  end

endmodule

[verif/date_difference_in_days_checker.sv]
// ----------------------------------------------------------------------------
// date_difference_in_days_checker
// watches both queue channels of the date difference block, predicts the
// day difference of every accepted date pair and compares it field by field
// against the result transfers in order
// ----------------------------------------------------------------------------
module date_difference_in_days_checker import dd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  logic    full,
  input  dd_in_t  in_data,
  input  logic    pop,
  input  logic    empty,
  input  dd_out_t out_data,
  output int      mismatch_count,
  output int      results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // days before the first of each month, common year
  localparam int unsigned DAYS_BEFORE_MONTH [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };
  localparam int PRINT_CAP = 100;

  dd_out_t expected_diffs [$];
  int      printed;

  initial begin
    mismatch_count = 0;
    results_due    = 0;
    printed        = 0;
  end

  // day number from 1 jan of year 0, proleptic gregorian, year 0 leap
  function automatic bit date_to_day_count(input logic [31:0] bcd,
                                           output int unsigned count);
    int unsigned digit [8];
    int unsigned day, month, year, leaps, prior;
    bit          leap;
    count = 0;
    for (int i = 0; i < 8; i++) begin
      digit[i] = bcd[31-4*i -: 4];
      if (digit[i] > 9) return 1'b0;
    end
    day   = digit[0] * 10 + digit[1];
    month = digit[2] * 10 + digit[3];
    year  = digit[4] * 1000 + digit[5] * 100 + digit[6] * 10 + digit[7];
    if (month < 1 || month > 12) return 1'b0;
    if (year == 0) begin
      leaps = 0;
    end else begin
      prior = year - 1;
      leaps = prior / 4 - prior / 100 + prior / 400 + 1;
    end
    leap  = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    count = 365 * year + leaps + DAYS_BEFORE_MONTH[month-1] + day;
    if (month > 2 && leap) count = count + 1;
    return 1'b1;
  endfunction

  function automatic dd_out_t predict_difference(input dd_in_t pair);
    int unsigned first_days, second_days;
    bit          first_ok, second_ok;
    int          diff;
    dd_out_t     r;
    first_ok  = date_to_day_count(pair.first_date_bcd, first_days);
    second_ok = date_to_day_count(pair.second_date_bcd, second_days);
    r = '0;
    if (first_ok && second_ok) begin
      diff = int'(first_days) - int'(second_days);
      r.day_difference = diff[DIFF_W-1:0];
    end else begin
      r.bad_input = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (printed < PRINT_CAP) $display("%0t ns mismatch: %s", $time, what);
    printed++;
  endtask

  // result side first, then the new expectation from this edge's input transfer
  always @(posedge clk) begin
    dd_out_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_diffs.size() == 0) begin
          report_mismatch($sformatf("unexpected result diff %0d bad %0b",
                                    out_data.day_difference, out_data.bad_input));
        end else begin
          want = expected_diffs.pop_front();
          if (out_data.day_difference !== want.day_difference)
            report_mismatch($sformatf("day_difference expected %0d got %0d",
                                      want.day_difference, out_data.day_difference));
          if (out_data.bad_input !== want.bad_input)
            report_mismatch($sformatf("bad_input expected %0b got %0b",
                                      want.bad_input, out_data.bad_input));
        end
      end
      if (push && !full) expected_diffs.push_back(predict_difference(in_data));
    end
    results_due = expected_diffs.size();
  end

endmodule

[verif/date_difference_in_days_tb.sv]
// ----------------------------------------------------------------------------
// date_difference_in_days_tb
// drives bcd date pairs into the date difference block, directed corner
// dates first and then about nine hundred random pairs, with random gaps on
// the input and random stalls on the result side; a checker beside the
// block predicts and compares every result transfer
// ----------------------------------------------------------------------------
module date_difference_in_days_tb;
  import dd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PAIRS = 930;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;     // covers the year stage, day-number stage and output queue plus margin

  logic    clk;
  logic    rst_n;
  logic    push;
  logic    full;
  dd_in_t  in_data;
  logic    pop;
  logic    empty;
  dd_out_t out_data;

  int      mismatch_count;
  int      results_due;
  int      cycles;
  bit      calm;      // stretch with no idling on either side
  int      pop_hold;  // cycles of result stall still to go

  date_difference_in_days DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

  date_difference_in_days_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data        (in_data),
    .pop            (pop),
    .empty          (empty),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit; also reshuffles the calm stretches
  initial begin
    cycles = 0;
    calm   = 1'b0;
  end
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // idle length: mostly short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side: pop high except during random stalls, changed at falling edge
  initial begin
    pop      = 1'b0;
    pop_hold = 0;
  end
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 20) pop_hold <= pick_gap();
    end
  end

  // ddmmyyyy bcd from decimal parts
  function automatic logic [31:0] pack_date(input int d, input int m, input int y);
    return {4'(d / 10), 4'(d % 10), 4'(m / 10), 4'(m % 10),
            4'(y / 1000), 4'((y / 100) % 10), 4'((y / 10) % 10), 4'(y % 10)};
  endfunction

  // random legal date; day mostly 1..31 but the full 00..99 range is allowed
  function automatic logic [31:0] random_date();
    int d, m, y, roll;
    d = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
    m = $urandom_range(1, 12);
    roll = $urandom_range(0, 9);
    case (roll)
      0:       y = 0;
      1:       y = 9999;
      2:       y = $urandom_range(0, 99) * 100;  // century years, some divisible by 400
      3:       y = $urandom_range(1995, 2005);
      default: y = $urandom_range(0, 9999);
    endcase
    return pack_date(d, m, y);
  endfunction

  // legal date with one nibble forced above 9
  function automatic logic [31:0] spoil_digit(input logic [31:0] bcd, input int pos);
    logic [31:0] r;
    r = bcd;
    r[31-4*pos -: 4] = 4'($urandom_range(10, 15));
    return r;
  endfunction

  // legal digits but month 00 or 13..19
  function automatic logic [31:0] spoil_month(input logic [31:0] bcd);
    logic [31:0] r;
    r = bcd;
    r[23:16] = ($urandom_range(0, 3) == 0) ? 8'h00 : {4'h1, 4'($urandom_range(3, 9))};
    return r;
  endfunction

  // one input transfer; returns at the falling edge after acceptance
  task automatic send_pair(input logic [31:0] first_bcd, input logic [31:0] second_bcd);
    in_data.first_date_bcd  <= first_bcd;
    in_data.second_date_bcd <= second_bcd;
    push                    <= 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // lower push for a random idle stretch, or keep it high back to back
  task automatic maybe_idle();
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 30) gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_random_pair();
    int          roll;
    logic [31:0] a, b;
    roll = $urandom_range(0, 99);
    a = random_date();
    b = random_date();
    if (roll < 72) begin
      // legal pair, the bulk of the run
    end else if (roll < 80) begin
      a = $urandom();
      b = $urandom();
    end else if (roll < 90) begin
      if ($urandom_range(0, 1)) a = spoil_month(a);
      else b = spoil_month(b);
    end else begin
      if ($urandom_range(0, 1)) a = spoil_digit(a, $urandom_range(0, 7));
      else b = spoil_digit(b, $urandom_range(0, 7));
    end
    send_pair(a, b);
  endtask

  initial begin
    logic [31:0] base;
    push    = 1'b0;
    in_data = '0;
    rst_n   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed corners
    send_pair(pack_date(1, 1, 2000), pack_date(1, 1, 2000));    // same date
    send_pair(pack_date(99, 12, 9999), pack_date(0, 1, 0));     // largest positive
    maybe_idle();
    send_pair(pack_date(0, 1, 0), pack_date(99, 12, 9999));     // largest negative
    send_pair(pack_date(29, 2, 2000), pack_date(1, 3, 2000));   // 400-year leap
    send_pair(pack_date(1, 3, 1900), pack_date(28, 2, 1900));   // century, no leap
    maybe_idle();
    send_pair(pack_date(1, 3, 2004), pack_date(1, 3, 2003));
    send_pair(pack_date(1, 3, 0), pack_date(1, 1, 1));          // year zero leap
    send_pair(pack_date(31, 12, 9999), pack_date(1, 1, 0));
    send_pair(pack_date(0, 1, 0), pack_date(0, 1, 0));          // day 00, zero count
    send_pair(32'h0101_0000, 32'hFFFF_FFFF);                    // all nibbles bad
    send_pair(32'h0000_0000, 32'h0000_0000);                    // month 00 on both
    maybe_idle();
    send_pair(pack_date(15, 0, 2020), pack_date(15, 6, 2020));  // month 00
    send_pair(pack_date(15, 6, 2020), pack_date(15, 13, 2020)); // month 13
    send_pair(32'h1519_2020, pack_date(15, 12, 2020));          // month 19
    send_pair(pack_date(15, 12, 2020), pack_date(15, 1, 2020)); // months 12 and 01
    // non-decimal nibble in every digit position, alternating sides
    base = pack_date(15, 6, 2020);
    for (int pos = 0; pos < 8; pos++) begin
      if (pos % 2 == 0) send_pair(spoil_digit(base, pos), base);
      else send_pair(base, spoil_digit(base, pos));
    end

    // random part; halfway the sender holds off until the block has drained
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      maybe_idle();
      if (n == RANDOM_PAIRS / 2) begin
        push <= 1'b0;
        @(negedge clk);
        while (results_due != 0) @(negedge clk);
      end
      send_random_pair();
    end
    push <= 1'b0;

    // drain, then a short tail to catch stray results
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && results_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
